>>> rtl/msstep_pkg.sv
// ----------------------------------------------------------------------------
// msstep_pkg
// Types, constants and helper functions shared by the mass-spring step unit.
// ----------------------------------------------------------------------------
package msstep_pkg;

   localparam int MAX_MASSES  = 64;
   localparam int MAX_SPRINGS = 64;

   localparam int MIDX_W = $clog2(MAX_MASSES);
   localparam int SIDX_W = $clog2(MAX_SPRINGS);
   localparam int MCNT_W = $clog2(MAX_MASSES + 1);
   localparam int SCNT_W = $clog2(MAX_SPRINGS + 1);

   localparam int END_W   = 6;
   localparam int CSR_W   = 2;
   localparam int MUL_W   = 34;
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SUM_W   = 66;
   localparam int DIV_W   = 64;
   localparam int DEN_W   = 34;
   localparam int DCNT_W  = $clog2(DIV_W + 1);
   localparam int RAD_W   = 68;
   localparam int ROOT_W  = RAD_W / 2;
   localparam int SRREM_W = ROOT_W + 2;
   localparam int SCNT2_W = $clog2(ROOT_W + 1);

   typedef enum logic [1:0] {
      CMD_LOAD_MASS   = 2'd0,
      CMD_LOAD_SPRING = 2'd1,
      CMD_STEP        = 2'd2,
      CMD_READ_MASS   = 2'd3
   } cmd_type;

   typedef enum logic [CSR_W-1:0] {
      CSR_TIME_STEP      = 2'd0,
      CSR_ACTIVE_MASSES  = 2'd1,
      CSR_ACTIVE_SPRINGS = 2'd2
   } csr_index_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_READ, ST_SPR_NEXT, ST_SPR_WAIT, ST_RD_A, ST_RD_B, ST_SQ, ST_SQ_ACC,
      ST_SQRT_WAIT, ST_FORCE, ST_COMP, ST_COMP_DIV, ST_COMP_DONE, ST_PUSH, ST_PUSH_DIV,
      ST_PUSH_WR, ST_MV_NEXT, ST_MV_RD, ST_MV_MUL, ST_MV_ACC, ST_MV_WR, ST_MUL_WAIT,
      ST_DIV_WAIT
   } state_type;

   typedef struct packed {
      logic [30:0]        mass;
      logic signed [31:0] pos_x;
      logic signed [31:0] pos_y;
      logic signed [31:0] pos_z;
   } mass_entry_type;

   typedef struct packed {
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } vel_entry_type;

   typedef struct packed {
      logic [END_W-1:0] end_a;
      logic [END_W-1:0] end_b;
      logic [30:0]      stiffness;
      logic [30:0]      rest_length;
   } spring_entry_type;

   typedef struct packed {
      logic [1:0]         command;
      logic [5:0]         slot;
      logic [30:0]        mass_amount;
      logic signed [31:0] load_x;
      logic signed [31:0] load_y;
      logic signed [31:0] load_z;
      logic [END_W-1:0]   end_a;
      logic [END_W-1:0]   end_b;
      logic [30:0]        stiffness;
      logic [30:0]        rest_length;
   } req_type;

   typedef struct packed {
      logic               status;
      logic [5:0]         read_slot;
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] out_vx;
      logic signed [31:0] out_vy;
      logic signed [31:0] out_vz;
   } rsp_type;

   typedef struct packed {
      logic [30:0] time_step;
      logic [6:0]  active_masses;
      logic [6:0]  active_springs;
   } cfg_type;

   typedef struct packed {
      logic              mass_we;
      logic [MIDX_W-1:0] mass_waddr;
      mass_entry_type    mass_wdata;
      logic [MIDX_W-1:0] mass_raddr;
      logic              vel_we;
      logic [MIDX_W-1:0] vel_waddr;
      vel_entry_type     vel_wdata;
      logic [MIDX_W-1:0] vel_raddr;
      logic              spr_we;
      logic [SIDX_W-1:0] spr_waddr;
      spring_entry_type  spr_wdata;
      logic [SIDX_W-1:0] spr_raddr;
   } mem_req_type;

   typedef struct packed {
      mass_entry_type   mass_rdata;
      vel_entry_type    vel_rdata;
      spring_entry_type spr_rdata;
   } mem_rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      logic signed [31:0] r;
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < -64'sh0000_0000_8000_0000) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

   function automatic logic [MCNT_W-1:0] mass_count(input logic [6:0] act);
      logic [MCNT_W-1:0] r;
      if (int'(act) < MAX_MASSES) begin
         r = MCNT_W'(act);
      end else begin
         r = MCNT_W'(MAX_MASSES);
      end
      return r;
   endfunction

   function automatic logic [SCNT_W-1:0] spring_count(input logic [6:0] act);
      logic [SCNT_W-1:0] r;
      if (int'(act) < MAX_SPRINGS) begin
         r = SCNT_W'(act);
      end else begin
         r = SCNT_W'(MAX_SPRINGS);
      end
      return r;
   endfunction

endpackage

>>> rtl/mass_spring_step_unit.sv
// ----------------------------------------------------------------------------
// mass_spring_step_unit
// Mass-spring system in Q16.16 fixed point advanced by symplectic Euler steps.
//
// A command transaction is accepted on a clock edge with start high and busy
// low. Commands load a mass, load a spring, run one time step or read a mass.
// Every command gives exactly one result, shown on the rsp_ ports for a single
// cycle while rsp_valid is high; the receiver cannot stall it.
// Loads answer in the cycle after acceptance and keep busy low, so a new
// command may follow at once. A read of a slot in range goes through ST_READ,
// where the RAM data are taken into the registered result. A step walks the
// active springs, then the active masses. Each spring that is in range and not
// of zero length runs the serial square root and up to nine passes through the
// serial divider. Each active mass is then moved one axis at a time.
// The user must write registers on the csr_ port only while the block is idle; the block itself does not enforce this.
// Reset returns the registers to their defaults and marks every velocity as
// zero; the other tables hold no data until loaded.
// ----------------------------------------------------------------------------
module mass_spring_step_unit (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_command,
   input  logic [5:0]         req_slot,
   input  logic [30:0]        req_mass_amount,
   input  logic signed [31:0] req_load_x,
   input  logic signed [31:0] req_load_y,
   input  logic signed [31:0] req_load_z,
   input  logic [5:0]         req_end_a,
   input  logic [5:0]         req_end_b,
   input  logic [30:0]        req_stiffness,
   input  logic [30:0]        req_rest_length,
   output logic               rsp_valid,
   output logic               rsp_status,
   output logic [5:0]         rsp_read_slot,
   output logic signed [31:0] rsp_out_x,
   output logic signed [31:0] rsp_out_y,
   output logic signed [31:0] rsp_out_z,
   output logic signed [31:0] rsp_out_vx,
   output logic signed [31:0] rsp_out_vy,
   output logic signed [31:0] rsp_out_vz,
   input  logic               csr_wr_en,
   input  logic [1:0]         csr_index,
   input  logic [30:0]        csr_wr_data
);
   import msstep_pkg::*;

   cfg_type          cfg_ff, cfg_in;
   logic             vel_valid_ff [MAX_MASSES];
   logic             vel_ok_ff;
   req_type          req;
   rsp_type          rsp;
   mem_req_type      mem_req;
   mem_rsp_type      mem_rsp;
   mass_entry_type   mass_rdata;
   vel_entry_type    vel_rdata;
   spring_entry_type spr_rdata;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_TIME_STEP:      cfg_in.time_step      = csr_wr_data;
            CSR_ACTIVE_MASSES:  cfg_in.active_masses  = csr_wr_data[6:0];
            CSR_ACTIVE_SPRINGS: cfg_in.active_springs = csr_wr_data[6:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.time_step      <= 31'd6554;
         cfg_ff.active_masses  <= '0;
         cfg_ff.active_springs <= '0;
         for (int n = 0; n < MAX_MASSES; n++) begin
            vel_valid_ff[n] <= 1'b0;
         end
         vel_ok_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (mem_req.vel_we) begin
            vel_valid_ff[mem_req.vel_waddr] <= 1'b1;
         end
         vel_ok_ff <= vel_valid_ff[mem_req.vel_raddr];
      end
   end

   msstep_ram #(.WIDTH($bits(mass_entry_type)), .DEPTH(MAX_MASSES)) u_mass_ram (
      .clock   (clock),
      .wr_en   (mem_req.mass_we),
      .wr_addr (mem_req.mass_waddr),
      .wr_data (mem_req.mass_wdata),
      .rd_addr (mem_req.mass_raddr),
      .rd_data (mass_rdata)
   );

   msstep_ram #(.WIDTH($bits(vel_entry_type)), .DEPTH(MAX_MASSES)) u_vel_ram (
      .clock   (clock),
      .wr_en   (mem_req.vel_we),
      .wr_addr (mem_req.vel_waddr),
      .wr_data (mem_req.vel_wdata),
      .rd_addr (mem_req.vel_raddr),
      .rd_data (vel_rdata)
   );

   msstep_ram #(.WIDTH($bits(spring_entry_type)), .DEPTH(MAX_SPRINGS)) u_spr_ram (
      .clock   (clock),
      .wr_en   (mem_req.spr_we),
      .wr_addr (mem_req.spr_waddr),
      .wr_data (mem_req.spr_wdata),
      .rd_addr (mem_req.spr_raddr),
      .rd_data (spr_rdata)
   );

   assign mem_rsp.mass_rdata = mass_rdata;
   assign mem_rsp.vel_rdata  = vel_ok_ff ? vel_rdata : '0;
   assign mem_rsp.spr_rdata  = spr_rdata;

   assign req.command     = req_command;
   assign req.slot        = req_slot;
   assign req.mass_amount = req_mass_amount;
   assign req.load_x      = req_load_x;
   assign req.load_y      = req_load_y;
   assign req.load_z      = req_load_z;
   assign req.end_a       = req_end_a;
   assign req.end_b       = req_end_b;
   assign req.stiffness   = req_stiffness;
   assign req.rest_length = req_rest_length;

   msstep_core u_core (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req       (req),
      .cfg       (cfg_ff),
      .mem_rsp   (mem_rsp),
      .mem_req   (mem_req),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp       (rsp)
   );

   assign rsp_status    = rsp.status;
   assign rsp_read_slot = rsp.read_slot;
   assign rsp_out_x     = rsp.out_x;
   assign rsp_out_y     = rsp.out_y;
   assign rsp_out_z     = rsp.out_z;
   assign rsp_out_vx    = rsp.out_vx;
   assign rsp_out_vy    = rsp.out_vy;
   assign rsp_out_vz    = rsp.out_vz;

endmodule

>>> rtl/msstep_ram.sv
// ----------------------------------------------------------------------------
// msstep_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module msstep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/msstep_div.sv
// ----------------------------------------------------------------------------
// msstep_div
// Serial restoring divider: one quotient bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module msstep_div (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [msstep_pkg::DIV_W-1:0]  dividend,
   input  logic [msstep_pkg::DEN_W-1:0]  divisor,
   output logic                          done,
   output logic [msstep_pkg::DIV_W-1:0]  quotient
);
   import msstep_pkg::*;

   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              done_ff, done_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [DEN_W:0]    rem_sh;

   assign rem_sh = {rem_ff[DEN_W-1:0], quo_ff[DIV_W-1]};

   always_comb begin
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = DCNT_W'(DIV_W);
         quo_in = dividend;
         rem_in = '0;
         den_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == DCNT_W'(1));
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

>>> rtl/msstep_sqrt.sv
// ----------------------------------------------------------------------------
// msstep_sqrt
// Serial integer square root: one root bit per cycle, done pulses at the end.
// ----------------------------------------------------------------------------
module msstep_sqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [msstep_pkg::RAD_W-1:0]  radicand,
   output logic                          done,
   output logic [msstep_pkg::ROOT_W-1:0] root
);
   import msstep_pkg::*;

   logic [SCNT2_W-1:0] cnt_ff, cnt_in;
   logic               done_ff, done_in;
   logic [RAD_W-1:0]   rad_ff, rad_in;
   logic [ROOT_W-1:0]  root_ff, root_in;
   logic [SRREM_W-1:0] rem_ff, rem_in;
   logic [SRREM_W+1:0] rem_sh;
   logic [SRREM_W+1:0] trial;

   assign rem_sh = {rem_ff, rad_ff[RAD_W-1:RAD_W-2]};
   assign trial  = {2'b00, root_ff, 2'b01};

   always_comb begin
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      root_in = root_ff;
      rem_in  = rem_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in  = SCNT2_W'(ROOT_W);
         rad_in  = radicand;
         root_in = '0;
         rem_in  = '0;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == SCNT2_W'(1));
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            rem_in  = SRREM_W'(rem_sh - trial);
            root_in = {root_ff[ROOT_W-2:0], 1'b1};
         end else begin
            rem_in  = SRREM_W'(rem_sh);
            root_in = {root_ff[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rad_ff  <= rad_in;
      root_ff <= root_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/msstep_core.sv
// ----------------------------------------------------------------------------
// msstep_core
// Command sequencer and datapath: walks the spring and mass tables held in the
// RAMs, with a shared multiplier, a serial divider and a serial square root.
// ----------------------------------------------------------------------------
module msstep_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  msstep_pkg::req_type      req,
   input  msstep_pkg::cfg_type      cfg,
   input  msstep_pkg::mem_rsp_type  mem_rsp,
   output msstep_pkg::mem_req_type  mem_req,
   output logic                     busy,
   output logic                     rsp_valid,
   output msstep_pkg::rsp_type      rsp
);
   import msstep_pkg::*;

   state_type          state_ff, state_in, ret_ff, ret_in;
   logic               side_ff, side_in;
   logic [1:0]         ax_ff, ax_in;
   logic [SCNT_W-1:0]  s_ff, s_in;
   logic [MCNT_W-1:0]  i_ff, i_in;
   logic [MIDX_W-1:0]  a_ff, a_in, b_ff, b_in;
   logic [30:0]        k_ff, k_in, rest_ff, rest_in;
   logic [30:0]        mass_a_ff, mass_a_in, mass_b_ff, mass_b_in;
   logic signed [31:0] pos_ff [3];
   logic signed [31:0] pos_in [3];
   logic signed [31:0] vel_ff [3];
   logic signed [31:0] vel_in [3];
   logic [32:0]        d_mag_ff [3];
   logic [32:0]        d_mag_in [3];
   logic [2:0]         d_neg_ff, d_neg_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic [ROOT_W-1:0]  dist_ff, dist_in;
   logic               e_neg_ff, e_neg_in;
   logic [30:0]        fm_ff, fm_in, comp_ff, comp_in;
   logic [MUL_W-1:0]   mul_a_ff, mul_a_in, mul_b_ff, mul_b_in;
   logic [PROD_W-1:0]  prod_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [MCNT_W-1:0]  mcount;
   logic [SCNT_W-1:0]  scount;
   logic signed [31:0] pos_rd [3];
   logic signed [31:0] vel_rd [3];
   logic signed [32:0] diff [3];
   logic signed [35:0] e_val;
   logic [MUL_W-1:0]   e_mag;
   logic [30:0]        fm_sat;
   logic [30:0]        push_mass;
   logic               push_neg;
   logic signed [63:0] vel_sum;
   logic [31:0]        vel_mag;
   logic [47:0]        delta;
   logic signed [63:0] pos_sum;
   logic               slot_ok_m, slot_ok_s;
   logic               div_start, div_done;
   logic [DIV_W-1:0]   div_num, quot;
   logic [DEN_W-1:0]   div_den;
   logic               sq_start, sq_done;
   logic [ROOT_W-1:0]  sq_root;
   logic [RAD_W-1:0]   sq_rad;
   vel_entry_type      vel_new;

   msstep_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (quot)
   );

   msstep_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sq_start),
      .radicand (sq_rad),
      .done     (sq_done),
      .root     (sq_root)
   );

   assign mcount    = mass_count(cfg.active_masses);
   assign scount    = spring_count(cfg.active_springs);
   assign slot_ok_m = int'(req.slot) < int'(mcount);
   assign slot_ok_s = int'(req.slot) < int'(scount);

   assign pos_rd[0] = mem_rsp.mass_rdata.pos_x;
   assign pos_rd[1] = mem_rsp.mass_rdata.pos_y;
   assign pos_rd[2] = mem_rsp.mass_rdata.pos_z;
   assign vel_rd[0] = mem_rsp.vel_rdata.vel_x;
   assign vel_rd[1] = mem_rsp.vel_rdata.vel_y;
   assign vel_rd[2] = mem_rsp.vel_rdata.vel_z;

   always_comb begin
      for (int n = 0; n < 3; n++) begin
         diff[n] = {pos_rd[n][31], pos_rd[n]} - {pos_ff[n][31], pos_ff[n]};
      end
   end

   assign sq_rad    = RAD_W'(sum_ff + prod_ff[SUM_W-1:0]);
   assign e_val     = $signed({2'b00, sq_root}) - $signed({5'b00000, rest_ff});
   assign e_mag     = MUL_W'(e_val < 0 ? -e_val : e_val);
   assign fm_sat    = (|prod_ff[PROD_W-1:47]) ? 31'h7FFF_FFFF : prod_ff[46:16];
   assign push_mass = side_ff ? mass_b_ff : mass_a_ff;
   assign push_neg  = e_neg_ff ^ d_neg_ff[ax_ff] ^ side_ff;
   assign vel_sum   = $signed({{32{vel_rd[ax_ff][31]}}, vel_rd[ax_ff]})
                    + (push_neg ? -$signed(quot) : $signed(quot));
   assign vel_mag   = vel_ff[ax_ff][31] ? 32'(-vel_ff[ax_ff]) : 32'(vel_ff[ax_ff]);
   assign delta     = prod_ff[63:16];
   assign pos_sum   = $signed({{32{pos_ff[ax_ff][31]}}, pos_ff[ax_ff]})
                    + (vel_ff[ax_ff][31] ? -$signed({16'h0000, delta})
                                          : $signed({16'h0000, delta}));

   always_comb begin
      vel_new = mem_rsp.vel_rdata;
      case (ax_ff)
         2'd0:    vel_new.vel_x = sat32(vel_sum);
         2'd1:    vel_new.vel_y = sat32(vel_sum);
         default: vel_new.vel_z = sat32(vel_sum);
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      side_in      = side_ff;
      ax_in        = ax_ff;
      s_in         = s_ff;
      i_in         = i_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      k_in         = k_ff;
      rest_in      = rest_ff;
      mass_a_in    = mass_a_ff;
      mass_b_in    = mass_b_ff;
      pos_in       = pos_ff;
      vel_in       = vel_ff;
      d_mag_in     = d_mag_ff;
      d_neg_in     = d_neg_ff;
      sum_in       = sum_ff;
      dist_in      = dist_ff;
      e_neg_in     = e_neg_ff;
      fm_in        = fm_ff;
      comp_in      = comp_ff;
      mul_a_in     = mul_a_ff;
      mul_b_in     = mul_b_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = rsp_ff;
      div_start    = 1'b0;
      div_num      = prod_ff[DIV_W-1:0];
      div_den      = dist_ff;
      sq_start     = 1'b0;

      mem_req            = '0;
      mem_req.mass_raddr = MIDX_W'(req.slot);
      mem_req.vel_raddr  = side_ff ? b_ff : a_ff;
      mem_req.spr_raddr  = s_ff[SIDX_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            mem_req.vel_raddr = MIDX_W'(req.slot);
            if (start) begin
               rsp_in = '0;
               case (cmd_type'(req.command))
                  CMD_LOAD_MASS: begin
                     rsp_valid_in              = 1'b1;
                     rsp_in.status             = !slot_ok_m;
                     mem_req.mass_we           = slot_ok_m;
                     mem_req.mass_waddr        = MIDX_W'(req.slot);
                     mem_req.mass_wdata.mass   = req.mass_amount;
                     mem_req.mass_wdata.pos_x  = req.load_x;
                     mem_req.mass_wdata.pos_y  = req.load_y;
                     mem_req.mass_wdata.pos_z  = req.load_z;
                     mem_req.vel_we            = slot_ok_m;
                     mem_req.vel_waddr         = MIDX_W'(req.slot);
                  end
                  CMD_LOAD_SPRING: begin
                     rsp_valid_in                  = 1'b1;
                     rsp_in.status                 = !slot_ok_s;
                     mem_req.spr_we                = slot_ok_s;
                     mem_req.spr_waddr             = SIDX_W'(req.slot);
                     mem_req.spr_wdata.end_a       = req.end_a;
                     mem_req.spr_wdata.end_b       = req.end_b;
                     mem_req.spr_wdata.stiffness   = req.stiffness;
                     mem_req.spr_wdata.rest_length = req.rest_length;
                  end
                  CMD_STEP: begin
                     s_in     = '0;
                     state_in = ST_SPR_NEXT;
                  end
                  default: begin
                     if (slot_ok_m) begin
                        rsp_in.read_slot = req.slot;
                        state_in         = ST_READ;
                     end else begin
                        rsp_valid_in  = 1'b1;
                        rsp_in.status = 1'b1;
                     end
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in  = 1'b1;
            rsp_in.out_x  = mem_rsp.mass_rdata.pos_x;
            rsp_in.out_y  = mem_rsp.mass_rdata.pos_y;
            rsp_in.out_z  = mem_rsp.mass_rdata.pos_z;
            rsp_in.out_vx = mem_rsp.vel_rdata.vel_x;
            rsp_in.out_vy = mem_rsp.vel_rdata.vel_y;
            rsp_in.out_vz = mem_rsp.vel_rdata.vel_z;
            state_in      = ST_IDLE;
         end
         ST_SPR_NEXT: begin
            if (s_ff >= scount) begin
               i_in     = '0;
               state_in = ST_MV_NEXT;
            end else begin
               state_in = ST_SPR_WAIT;
            end
         end
         ST_SPR_WAIT: begin
            mem_req.mass_raddr = MIDX_W'(mem_rsp.spr_rdata.end_a);
            a_in    = MIDX_W'(mem_rsp.spr_rdata.end_a);
            b_in    = MIDX_W'(mem_rsp.spr_rdata.end_b);
            k_in    = mem_rsp.spr_rdata.stiffness;
            rest_in = mem_rsp.spr_rdata.rest_length;
            if ((int'(mem_rsp.spr_rdata.end_a) >= int'(mcount))
                || (int'(mem_rsp.spr_rdata.end_b) >= int'(mcount))) begin
               s_in     = s_ff + 1'b1;
               state_in = ST_SPR_NEXT;
            end else begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: begin
            mem_req.mass_raddr = b_ff;
            pos_in    = pos_rd;
            mass_a_in = mem_rsp.mass_rdata.mass;
            state_in  = ST_RD_B;
         end
         ST_RD_B: begin
            mass_b_in = mem_rsp.mass_rdata.mass;
            for (int n = 0; n < 3; n++) begin
               d_neg_in[n] = diff[n][32];
               d_mag_in[n] = diff[n][32] ? 33'(-diff[n]) : 33'(diff[n]);
            end
            sum_in   = '0;
            ax_in    = '0;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            mul_a_in = MUL_W'(d_mag_ff[ax_ff]);
            mul_b_in = MUL_W'(d_mag_ff[ax_ff]);
            ret_in   = ST_SQ_ACC;
            state_in = ST_MUL_WAIT;
         end
         ST_SQ_ACC: begin
            sum_in = sum_ff + prod_ff[SUM_W-1:0];
            if (ax_ff == 2'd2) begin
               sq_start = 1'b1;
               ax_in    = '0;
               state_in = ST_SQRT_WAIT;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = ST_SQ;
            end
         end
         ST_SQRT_WAIT: begin
            if (sq_done) begin
               dist_in = sq_root;
               if (sq_root == '0) begin
                  s_in     = s_ff + 1'b1;
                  state_in = ST_SPR_NEXT;
               end else begin
                  e_neg_in = e_val[35];
                  mul_a_in = e_mag;
                  mul_b_in = MUL_W'(k_ff);
                  ret_in   = ST_FORCE;
                  state_in = ST_MUL_WAIT;
               end
            end
         end
         ST_FORCE: begin
            fm_in    = fm_sat;
            ax_in    = '0;
            state_in = ST_COMP;
         end
         ST_COMP: begin
            mul_a_in = MUL_W'(fm_ff);
            mul_b_in = MUL_W'(d_mag_ff[ax_ff]);
            ret_in   = ST_COMP_DIV;
            state_in = ST_MUL_WAIT;
         end
         ST_COMP_DIV: begin
            div_start = 1'b1;
            div_den   = dist_ff;
            ret_in    = ST_COMP_DONE;
            state_in  = ST_DIV_WAIT;
         end
         ST_COMP_DONE: begin
            comp_in  = quot[30:0];
            side_in  = 1'b0;
            state_in = ST_PUSH;
         end
         ST_PUSH, ST_PUSH_WR: begin
            if ((state_ff == ST_PUSH) && (push_mass != '0)) begin
               mul_a_in = MUL_W'(comp_ff);
               mul_b_in = MUL_W'(cfg.time_step);
               ret_in   = ST_PUSH_DIV;
               state_in = ST_MUL_WAIT;
            end else begin
               if (state_ff == ST_PUSH_WR) begin
                  mem_req.vel_we    = 1'b1;
                  mem_req.vel_waddr = side_ff ? b_ff : a_ff;
                  mem_req.vel_wdata = vel_new;
               end
               if (!side_ff) begin
                  side_in  = 1'b1;
                  state_in = ST_PUSH;
               end else if (ax_ff == 2'd2) begin
                  side_in  = 1'b0;
                  s_in     = s_ff + 1'b1;
                  state_in = ST_SPR_NEXT;
               end else begin
                  side_in  = 1'b0;
                  ax_in    = ax_ff + 1'b1;
                  state_in = ST_COMP;
               end
            end
         end
         ST_PUSH_DIV: begin
            div_start = 1'b1;
            div_den   = DEN_W'(push_mass);
            ret_in    = ST_PUSH_WR;
            state_in  = ST_DIV_WAIT;
         end
         ST_MV_NEXT: begin
            mem_req.mass_raddr = i_ff[MIDX_W-1:0];
            mem_req.vel_raddr  = i_ff[MIDX_W-1:0];
            if (i_ff >= mcount) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_MV_RD;
            end
         end
         ST_MV_RD: begin
            pos_in    = pos_rd;
            vel_in    = vel_rd;
            mass_a_in = mem_rsp.mass_rdata.mass;
            ax_in     = '0;
            state_in  = ST_MV_MUL;
         end
         ST_MV_MUL: begin
            mul_a_in = MUL_W'(vel_mag);
            mul_b_in = MUL_W'(cfg.time_step);
            ret_in   = ST_MV_ACC;
            state_in = ST_MUL_WAIT;
         end
         ST_MV_ACC: begin
            pos_in[ax_ff] = sat32(pos_sum);
            if (ax_ff == 2'd2) begin
               state_in = ST_MV_WR;
            end else begin
               ax_in    = ax_ff + 1'b1;
               state_in = ST_MV_MUL;
            end
         end
         ST_MV_WR: begin
            mem_req.mass_we          = 1'b1;
            mem_req.mass_waddr       = i_ff[MIDX_W-1:0];
            mem_req.mass_wdata.mass  = mass_a_ff;
            mem_req.mass_wdata.pos_x = pos_ff[0];
            mem_req.mass_wdata.pos_y = pos_ff[1];
            mem_req.mass_wdata.pos_z = pos_ff[2];
            i_in     = i_ff + 1'b1;
            state_in = ST_MV_NEXT;
         end
         ST_MUL_WAIT: begin
            state_in = ret_ff;
         end
         ST_DIV_WAIT: begin
            if (div_done) begin
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff    <= ret_in;
      side_ff   <= side_in;
      ax_ff     <= ax_in;
      s_ff      <= s_in;
      i_ff      <= i_in;
      a_ff      <= a_in;
      b_ff      <= b_in;
      k_ff      <= k_in;
      rest_ff   <= rest_in;
      mass_a_ff <= mass_a_in;
      mass_b_ff <= mass_b_in;
      pos_ff    <= pos_in;
      vel_ff    <= vel_in;
      d_mag_ff  <= d_mag_in;
      d_neg_ff  <= d_neg_in;
      sum_ff    <= sum_in;
      dist_ff   <= dist_in;
      e_neg_ff  <= e_neg_in;
      fm_ff     <= fm_in;
      comp_ff   <= comp_in;
      mul_a_ff  <= mul_a_in;
      mul_b_ff  <= mul_b_in;
      prod_ff   <= mul_a_ff * mul_b_ff;
      rsp_ff    <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

>>> tb/mass_spring_step_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mass_spring_step_unit_test
// Self-checking testbench for the mass-spring step unit. A queue of commands
// is built phase by phase, each phase under its own register setting, and a
// driver presents them in bursts. Every accepted command is run through an
// independent fixed-point model of the tables, and each result is compared
// field by field with the oldest expected one.
// ----------------------------------------------------------------------------
module mass_spring_step_unit_test;
   import msstep_pkg::*;

   localparam longint CYCLE_LIMIT = 4000000;
   localparam logic [127:0] FORCE_MAX = 128'h7FFF_FFFF;
   localparam logic [127:0] DV_CLIP = 128'h2_0000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   logic [1:0]         req_command = '0;
   logic [5:0]         req_slot = '0;
   logic [30:0]        req_mass_amount = '0;
   logic signed [31:0] req_load_x = '0;
   logic signed [31:0] req_load_y = '0;
   logic signed [31:0] req_load_z = '0;
   logic [5:0]         req_end_a = '0;
   logic [5:0]         req_end_b = '0;
   logic [30:0]        req_stiffness = '0;
   logic [30:0]        req_rest_length = '0;
   logic               rsp_valid;
   logic               rsp_status;
   logic [5:0]         rsp_read_slot;
   logic signed [31:0] rsp_out_x;
   logic signed [31:0] rsp_out_y;
   logic signed [31:0] rsp_out_z;
   logic signed [31:0] rsp_out_vx;
   logic signed [31:0] rsp_out_vy;
   logic signed [31:0] rsp_out_vz;
   logic               csr_wr_en = 1'b0;
   logic [1:0]         csr_index = '0;
   logic [30:0]        csr_wr_data = '0;

   mass_spring_step_unit u_top (.*);

   always #5 clock = ~clock;

   req_type pending_cmds[$];
   rsp_type expected_rsps[$];
   int      mismatches = 0;
   int      accepted_cnt = 0;
   int      presented_cnt = 0;
   int      cmd_counts[4] = '{0, 0, 0, 0};
   int      refused_cnt = 0;
   longint  cycle_cnt = 0;
   bit      hold_sender = 1'b0;

   // Model state of the block.
   bit [30:0] mdl_dt;
   bit [6:0]  mdl_masses;
   bit [6:0]  mdl_springs;
   bit [30:0] mdl_mass[64];
   int        mdl_pos[3][64];
   int        mdl_vel[3][64];
   bit [5:0]  mdl_end_a[64];
   bit [5:0]  mdl_end_b[64];
   bit [30:0] mdl_k[64];
   bit [30:0] mdl_rest[64];

   // Generator view of which entries hold data.
   bit        gen_mass_ok[64];
   bit        gen_spring_ok[64];

   function automatic void queue_cmd(req_type r);
      pending_cmds.insert(pending_cmds.size(), r);
   endfunction

   function automatic int eff_count(bit [6:0] act);
      return (act > 7'd64) ? 64 : int'(act);
   endfunction

   function automatic int sat_add(int base, bit neg, logic [127:0] mag);
      longint s;
      if (mag > DV_CLIP) mag = DV_CLIP;
      s = longint'(base) + (neg ? -longint'(mag[63:0]) : longint'(mag[63:0]));
      if (s > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (s < -64'sd2147483648) return 32'h8000_0000;
      return int'(s);
   endfunction

   function automatic logic [33:0] floor_root(logic [67:0] rad);
      logic [71:0] rem;
      logic [71:0] root;
      logic [71:0] trial;
      rem = '0;
      root = '0;
      for (int i = 33; i >= 0; i--) begin
         rem = (rem << 2) | 72'(rad[2*i +: 2]);
         trial = (root << 2) | 72'd1;
         if (rem >= trial) begin
            rem = rem - trial;
            root = (root << 1) | 72'd1;
         end else begin
            root = root << 1;
         end
      end
      return root[33:0];
   endfunction

   function automatic void kick_velocity(int ax, int idx, bit neg, logic [127:0] comp);
      logic [127:0] dv;
      if (mdl_mass[idx] == 0) return;
      dv = (comp * 128'(mdl_dt)) / 128'(mdl_mass[idx]);
      mdl_vel[ax][idx] = sat_add(mdl_vel[ax][idx], neg, dv);
   endfunction

   function automatic void apply_spring(int s, int cnt);
      int           a;
      int           b;
      longint       d[3];
      logic [67:0]  rad;
      logic [127:0] mag;
      logic [127:0] span;
      logic [127:0] fm;
      logic [127:0] comp;
      longint       e;
      bit           neg;
      a = mdl_end_a[s];
      b = mdl_end_b[s];
      if (a >= cnt || b >= cnt) return;
      rad = '0;
      for (int ax = 0; ax < 3; ax++) begin
         d[ax] = longint'(mdl_pos[ax][b]) - longint'(mdl_pos[ax][a]);
         mag = 128'(d[ax] < 0 ? -d[ax] : d[ax]);
         rad = rad + 68'(mag * mag);
      end
      span = 128'(floor_root(rad));
      if (span == 0) return;
      e = longint'(span[63:0]) - longint'(mdl_rest[s]);
      mag = 128'(e < 0 ? -e : e);
      fm = (128'(mdl_k[s]) * mag) >> 16;
      if (fm > FORCE_MAX) fm = FORCE_MAX;
      for (int ax = 0; ax < 3; ax++) begin
         mag = 128'(d[ax] < 0 ? -d[ax] : d[ax]);
         comp = (fm * mag) / span;
         neg = (e < 0) != (d[ax] < 0);
         kick_velocity(ax, a, neg, comp);
         kick_velocity(ax, b, !neg, comp);
      end
   endfunction

   function automatic void advance_system();
      int           cnt;
      int           v;
      logic [127:0] delta;
      cnt = eff_count(mdl_masses);
      for (int s = 0; s < eff_count(mdl_springs); s++) apply_spring(s, cnt);
      for (int i = 0; i < cnt; i++) begin
         for (int ax = 0; ax < 3; ax++) begin
            v = mdl_vel[ax][i];
            delta = ((128'(v < 0 ? -longint'(v) : longint'(v))) * 128'(mdl_dt)) >> 16;
            mdl_pos[ax][i] = sat_add(mdl_pos[ax][i], v < 0, delta);
         end
      end
   endfunction

   function automatic rsp_type predict_command(req_type r);
      rsp_type o;
      o = '0;
      case (cmd_type'(r.command))
         CMD_LOAD_MASS: begin
            if (r.slot >= eff_count(mdl_masses)) begin
               o.status = 1'b1;
            end else begin
               mdl_mass[r.slot] = r.mass_amount;
               mdl_pos[0][r.slot] = r.load_x;
               mdl_pos[1][r.slot] = r.load_y;
               mdl_pos[2][r.slot] = r.load_z;
               for (int ax = 0; ax < 3; ax++) mdl_vel[ax][r.slot] = 0;
            end
         end
         CMD_LOAD_SPRING: begin
            if (r.slot >= eff_count(mdl_springs)) begin
               o.status = 1'b1;
            end else begin
               mdl_end_a[r.slot] = r.end_a;
               mdl_end_b[r.slot] = r.end_b;
               mdl_k[r.slot] = r.stiffness;
               mdl_rest[r.slot] = r.rest_length;
            end
         end
         CMD_STEP: advance_system();
         default: begin
            if (r.slot >= eff_count(mdl_masses)) begin
               o.status = 1'b1;
            end else begin
               o.read_slot = r.slot;
               o.out_x = mdl_pos[0][r.slot];
               o.out_y = mdl_pos[1][r.slot];
               o.out_z = mdl_pos[2][r.slot];
               o.out_vx = mdl_vel[0][r.slot];
               o.out_vy = mdl_vel[1][r.slot];
               o.out_vz = mdl_vel[2][r.slot];
            end
         end
      endcase
      return o;
   endfunction

   task automatic report_mismatch(string field, longint got, longint want);
      mismatches++;
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, field, got, want);
   endtask

   // Monitor: register writes, result checks and command acceptance.
   always @(posedge clock) begin
      rsp_type want;
      req_type r;
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("run exceeded its cycle limit");
         $display("mass_spring_step_unit regression: fail");
         $finish;
      end
      if (reset) begin
         mdl_dt = 31'd6554;
         mdl_masses = '0;
         mdl_springs = '0;
         for (int i = 0; i < 64; i++) begin
            for (int ax = 0; ax < 3; ax++) mdl_vel[ax][i] = 0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index_type'(csr_index))
               CSR_TIME_STEP:      mdl_dt = csr_wr_data;
               CSR_ACTIVE_MASSES:  mdl_masses = csr_wr_data[6:0];
               CSR_ACTIVE_SPRINGS: mdl_springs = csr_wr_data[6:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_read_slot !== want.read_slot)
                  report_mismatch("read_slot", rsp_read_slot, want.read_slot);
               if (rsp_out_x !== want.out_x) report_mismatch("out_x", rsp_out_x, want.out_x);
               if (rsp_out_y !== want.out_y) report_mismatch("out_y", rsp_out_y, want.out_y);
               if (rsp_out_z !== want.out_z) report_mismatch("out_z", rsp_out_z, want.out_z);
               if (rsp_out_vx !== want.out_vx)
                  report_mismatch("out_vx", rsp_out_vx, want.out_vx);
               if (rsp_out_vy !== want.out_vy)
                  report_mismatch("out_vy", rsp_out_vy, want.out_vy);
               if (rsp_out_vz !== want.out_vz)
                  report_mismatch("out_vz", rsp_out_vz, want.out_vz);
            end
         end
         if (start && !busy) begin
            r = '{req_command, req_slot, req_mass_amount, req_load_x, req_load_y,
                  req_load_z, req_end_a, req_end_b, req_stiffness, req_rest_length};
            want = predict_command(r);
            if (want.status) refused_cnt++;
            cmd_counts[r.command]++;
            expected_rsps.insert(expected_rsps.size(), want);
            accepted_cnt++;
         end
      end
   end

   // Driver: bursts of commands with random gaps between them.
   int burst_left = 4;
   int gap_left = 0;
   always @(negedge clock) begin
      req_type r;
      if (!reset && presented_cnt == accepted_cnt) begin
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (hold_sender || pending_cmds.size() == 0) begin
            start <= 1'b0;
         end else begin
            r = pending_cmds.pop_front();
            req_command <= r.command;
            req_slot <= r.slot;
            req_mass_amount <= r.mass_amount;
            req_load_x <= r.load_x;
            req_load_y <= r.load_y;
            req_load_z <= r.load_z;
            req_end_a <= r.end_a;
            req_end_b <= r.end_b;
            req_stiffness <= r.stiffness;
            req_rest_length <= r.rest_length;
            start <= 1'b1;
            presented_cnt++;
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            end
         end
      end
   end

   function automatic int rand_pos();
      case ($urandom_range(0, 11))
         0: return 32'h7FFF_FFFF;
         1: return 32'h8000_0000;
         2: return int'($urandom);
         default: return int'($urandom_range(0, 524288)) - 262144;
      endcase
   endfunction

   function automatic req_type noise_cmd(cmd_type c, int slot);
      req_type      r;
      logic [223:0] noise;
      noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
      r = noise[$bits(req_type)-1:0];
      r.command = c;
      r.slot = 6'(slot);
      return r;
   endfunction

   task automatic add_mass(int slot, int mcnt, int amount, int x, int y, int z);
      req_type r;
      r = noise_cmd(CMD_LOAD_MASS, slot);
      r.mass_amount = 31'(amount);
      r.load_x = x;
      r.load_y = y;
      r.load_z = z;
      if (slot < mcnt) gen_mass_ok[slot] = 1'b1;
      queue_cmd(r);
   endtask

   task automatic add_spring(int slot, int scnt, int a, int b, int k, int rest);
      req_type r;
      r = noise_cmd(CMD_LOAD_SPRING, slot);
      r.end_a = 6'(a);
      r.end_b = 6'(b);
      r.stiffness = 31'(k);
      r.rest_length = 31'(rest);
      if (slot < scnt) gen_spring_ok[slot] = 1'b1;
      queue_cmd(r);
   endtask

   task automatic add_random_mass(int slot, int mcnt);
      int amount;
      case ($urandom_range(0, 9))
         0: amount = 1;
         1: amount = 32'h7FFF_FFFF;
         2: amount = $urandom_range(1, 32'h7FFF_FFFF);
         default: amount = $urandom_range(16384, 262144);
      endcase
      add_mass(slot, mcnt, amount, rand_pos(), rand_pos(), rand_pos());
   endtask

   task automatic add_random_spring(int slot, int mcnt, int scnt);
      int a;
      int b;
      int k;
      int rest;
      a = (mcnt > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, mcnt - 1)
                                                   : $urandom_range(0, 63);
      b = (mcnt > 0 && $urandom_range(0, 7) != 0) ? $urandom_range(0, mcnt - 1)
                                                   : $urandom_range(0, 63);
      if ($urandom_range(0, 11) == 0) b = a;
      case ($urandom_range(0, 9))
         0: k = 0;
         1: k = 32'h7FFF_FFFF;
         2: k = $urandom_range(0, 32'h7FFF_FFFF);
         default: k = $urandom_range(0, 327680);
      endcase
      case ($urandom_range(0, 9))
         0: rest = 0;
         1: rest = 32'h7FFF_FFFF;
         2: rest = $urandom_range(0, 32'h7FFF_FFFF);
         default: rest = $urandom_range(0, 262144);
      endcase
      add_spring(slot, scnt, a, b, k, rest);
   endtask

   task automatic wait_idle();
      while (pending_cmds.size() != 0 || presented_cnt != accepted_cnt ||
             expected_rsps.size() != 0 || start) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_reg(csr_index_type idx, int value);
      csr_index <= idx;
      csr_wr_data <= 31'(value);
      csr_wr_en <= 1'b1;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // One phase: set the registers, fill every entry in use, then random traffic.
   task automatic run_phase(int dt, int masses, int springs, int n_random, int w_step);
      int mcnt;
      int scnt;
      int pick;
      wait_idle();
      write_reg(CSR_TIME_STEP, dt);
      write_reg(CSR_ACTIVE_MASSES, masses);
      write_reg(CSR_ACTIVE_SPRINGS, springs);
      mcnt = eff_count(7'(masses));
      scnt = eff_count(7'(springs));
      for (int i = 0; i < mcnt; i++) begin
         if (!gen_mass_ok[i] || $urandom_range(0, 1)) add_random_mass(i, mcnt);
      end
      for (int i = 0; i < scnt; i++) begin
         if (!gen_spring_ok[i] || $urandom_range(0, 1)) add_random_spring(i, mcnt, scnt);
      end
      for (int n = 0; n < n_random; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 30) begin
            add_random_mass($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                            : $urandom_range(0, (mcnt > 0) ? mcnt - 1 : 0), mcnt);
         end else if (pick < 50) begin
            add_random_spring($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                              : $urandom_range(0, (scnt > 0) ? scnt - 1 : 0), mcnt, scnt);
         end else if (pick < 50 + w_step) begin
            queue_cmd(noise_cmd(CMD_STEP, $urandom_range(0, 63)));
         end else begin
            queue_cmd(noise_cmd(CMD_READ_MASS,
               $urandom_range(0, 4) == 0 ? $urandom_range(0, 63)
               : $urandom_range(0, (mcnt > 0) ? mcnt - 1 : 0)));
         end
      end
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // Directed: extremes, refusals, degenerate springs and a short run.
      write_reg(CSR_ACTIVE_MASSES, 4);
      write_reg(CSR_ACTIVE_SPRINGS, 3);
      add_mass(0, 4, 65536, 32'h7FFF_FFFF, 32'h8000_0000, 0);
      add_mass(1, 4, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
      add_mass(2, 4, 1, 0, 0, 0);
      add_mass(3, 4, 131072, 65536, 0, 0);
      add_mass(4, 4, 65536, 1, 2, 3);
      add_mass(63, 4, 65536, 1, 2, 3);
      add_spring(0, 3, 2, 3, 65536, 32768);
      add_spring(1, 3, 2, 2, 32'h7FFF_FFFF, 0);
      add_spring(2, 3, 1, 63, 65536, 0);
      add_spring(3, 3, 0, 1, 65536, 0);
      queue_cmd(noise_cmd(CMD_READ_MASS, 4));
      queue_cmd(noise_cmd(CMD_READ_MASS, 63));
      queue_cmd(noise_cmd(CMD_STEP, 0));
      for (int i = 0; i < 4; i++) queue_cmd(noise_cmd(CMD_READ_MASS, i));
      add_spring(2, 3, 0, 1, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      queue_cmd(noise_cmd(CMD_STEP, 63));
      queue_cmd(noise_cmd(CMD_STEP, 0));
      for (int i = 0; i < 4; i++) queue_cmd(noise_cmd(CMD_READ_MASS, i));

      // Once the block has drained, hold the sender while a command waits in the queue.
      wait_idle();
      hold_sender = 1'b1;
      add_random_mass(3, 4);
      repeat (30) @(negedge clock);
      hold_sender = 1'b0;

      run_phase($urandom_range(1000, 20000), 6, 5, 50, 15);
      run_phase(0, 3, 2, 20, 20);
      run_phase(32'h7FFF_FFFF, 5, 4, 25, 15);
      run_phase(6554, 0, 0, 10, 20);
      run_phase(655, 127, 127, 6, 2);
      run_phase($urandom_range(0, 65536), 8, 8, 15, 12);

      wait_idle();
      repeat (20) @(negedge clock);
      $display("commands accepted: %0d (mass loads %0d, spring loads %0d, steps %0d, reads %0d)",
               accepted_cnt, cmd_counts[CMD_LOAD_MASS], cmd_counts[CMD_LOAD_SPRING],
               cmd_counts[CMD_STEP], cmd_counts[CMD_READ_MASS]);
      $display("refused by slot range: %0d, mismatches: %0d", refused_cnt, mismatches);
      if (mismatches == 0 && expected_rsps.size() == 0) begin
         $display("mass_spring_step_unit regression: pass");
      end else begin
         $display("mass_spring_step_unit regression: fail");
      end
      $finish;
   end

endmodule
